@@ rtl/core/scbsa_pkg.sv @@
// ----------------------------------------------------------------------------
// scbsa_pkg
// Shared types and codes of the size class bitmap slab allocator.
// ----------------------------------------------------------------------------
package scbsa_pkg;

    // request modes
    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_FREE  = 2'd1;
    localparam logic [1:0] MODE_ADD   = 2'd2;
    localparam logic [1:0] MODE_NOP   = 2'd3;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NEED_PAGE = 3'd1;
    localparam logic [2:0] ST_NO_EMPTY  = 3'd2;
    localparam logic [2:0] ST_BAD_FREE  = 3'd3;
    localparam logic [2:0] ST_RELEASED  = 3'd4;
    localparam logic [2:0] ST_ALL_REL   = 3'd5;

    // register indexes
    localparam logic REG_BLOCK_SIZE = 1'b0;
    localparam logic REG_BPP        = 1'b1;

    localparam int PAGE_SHIFT = 16;

    // classified request handed from front to back
    typedef struct packed {
        logic [1:0]  op;
        logic        bad;
        logic [47:0] page;
        logic [5:0]  slot;
        logic [9:0]  blk;
    } cmd_t;

    // one result
    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] addr;
        logic [47:0] rel;
        logic [5:0]  used;
    } res_t;

endpackage

@@ rtl/core/size_class_bitmap_slab_allocator.sv @@
// ----------------------------------------------------------------------------
// size_class_bitmap_slab_allocator
// Bitmap slab allocator for one size class over a set of page slots.
// ----------------------------------------------------------------------------
// steps: nop and rejected requests go straight to the result push; free
//   checks the bit and clears it, then relinks the slot when the page is
//   released; allocate walks the in-use ring slot by slot and skips full
//   bitmap words; add-page relinks the slot, then sweeps its bitmap clear
// throughput: one request at a time in the back end, set by its sequencer
//   and the slot and bitmap memories with one read and one write port each
// reset: rst_n asynchronous active low; no clearing pass, slot tables fall
//   back to reset values through per-slot valid bits
module size_class_bitmap_slab_allocator #(
    parameter int SLOTS        = 64,
    parameter int MAX_BLOCKS   = 1024,
    parameter int HEADER_BYTES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // request side
    input  logic        push,
    output logic        full,
    input  logic [1:0]  mode,
    input  logic [47:0] page_number,
    input  logic [5:0]  slot_index,
    input  logic [9:0]  block_index,
    // result side
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  status,
    output logic [63:0] block_address,
    output logic [47:0] released_page,
    output logic [5:0]  used_slot,
    // register writes
    input  logic        wr_en,
    input  logic        wr_index,
    input  logic [15:0] wr_data
);
    import scbsa_pkg::*;

    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

    // configuration registers
    logic [15:0]      block_size_reg;
    logic [10:0]      bpp_reg;
    logic [CNT_W-1:0] eff_bpp;

    // front to back request queue and result queue
    cmd_t                    cmd;
    logic                    cmd_valid, cmd_pop;
    res_t                    res, res_out;
    logic                    res_push, res_full;
    logic [$bits(res_t)-1:0] res_raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_reg <= 16'd64;
            bpp_reg        <= 11'd1024;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_BLOCK_SIZE: block_size_reg <= wr_data;
                REG_BPP:        bpp_reg        <= wr_data[10:0];
                default:        ;
            endcase
        end
    end

    // zero acts as one block, large values clamp to the bitmap size
    always_comb
    begin
        if (bpp_reg == '0)
        begin
            eff_bpp = CNT_W'(1);
        end
        else if (32'(bpp_reg) > 32'(MAX_BLOCKS))
        begin
            eff_bpp = CNT_W'(MAX_BLOCKS);
        end
        else
        begin
            eff_bpp = CNT_W'(bpp_reg);
        end
    end

    // front: take requests, screen free ranges, queue them
    scbsa_front #(
        .SLOTS      (SLOTS),
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .mode        (mode),
        .page_number (page_number),
        .slot_index  (slot_index),
        .block_index (block_index),
        .eff_bpp     (eff_bpp),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop)
    );

    // back: list walks, bitmap scans and table updates
    scbsa_engine #(
        .SLOTS        (SLOTS),
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop),
        .res_full   (res_full),
        .res_push   (res_push),
        .res        (res),
        .block_size (block_size_reg),
        .eff_bpp    (eff_bpp)
    );

    // result queue parts the back end from the consumer
    scbsa_fifo #(.W($bits(res_t))) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res),
        .full  (res_full),
        .pop   (pop),
        .dout  (res_raw),
        .empty (empty)
    );

    assign res_out       = res_t'(res_raw);
    assign status        = res_out.status;
    assign block_address = res_out.addr;
    assign released_page = res_out.rel;
    assign used_slot     = res_out.used;

    // back end only starts a request when the result queue has room
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into a full queue");

    // an address only comes with a good status
    a_addr_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != ST_OK) |-> (block_address == '0))
        else $error("block address on a failed request");

    // a released page only comes with a release status
    a_rel_only_release: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != ST_RELEASED && status != ST_ALL_REL) |-> (released_page == '0))
        else $error("released page without a release");

    // request queue pops only into a free back end with result room
    a_pop_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> (cmd_valid && !res_full))
        else $error("request taken without room");
endmodule

@@ rtl/core/scbsa_fifo.sv @@
// ----------------------------------------------------------------------------
// scbsa_fifo
// Two-entry queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module scbsa_fifo #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] din,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] dout,
    output logic         empty
);
    logic [W-1:0] data_mem [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;
    logic         do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = data_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_mem[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end
endmodule

@@ rtl/core/scbsa_front.sv @@
// ----------------------------------------------------------------------------
// scbsa_front
// Accepts requests, screens free requests for range, queues them.
// ----------------------------------------------------------------------------
module scbsa_front #(
    parameter int SLOTS      = 64,
    parameter int MAX_BLOCKS = 1024
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic [1:0]                           mode,
    input  logic [47:0]                          page_number,
    input  logic [5:0]                           slot_index,
    input  logic [9:0]                           block_index,
    input  logic [$clog2(MAX_BLOCKS+1)-1:0]      eff_bpp,
    output logic                                 cmd_valid,
    output scbsa_pkg::cmd_t                      cmd,
    input  logic                                 cmd_pop
);
    import scbsa_pkg::*;

    cmd_t cmd_in;
    logic [$bits(cmd_t)-1:0] cmd_raw;
    logic cmd_empty;

    always_comb
    begin
        cmd_in.op   = mode;
        cmd_in.page = page_number;
        cmd_in.slot = slot_index;
        cmd_in.blk  = block_index;
        // slot past the table or block past the page
        cmd_in.bad  = (32'(slot_index) >= 32'(SLOTS)) || (32'(block_index) >= 32'(eff_bpp));
    end

    scbsa_fifo #(.W($bits(cmd_t))) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (cmd_in),
        .full  (full),
        .pop   (cmd_pop),
        .dout  (cmd_raw),
        .empty (cmd_empty)
    );

    assign cmd       = cmd_t'(cmd_raw);
    assign cmd_valid = !cmd_empty;
endmodule

@@ rtl/core/scbsa_engine.sv @@
// ----------------------------------------------------------------------------
// scbsa_engine
// Sequencer over slot tables and bitmap memory: allocate, free, add page.
// ----------------------------------------------------------------------------
module scbsa_engine #(
    parameter int SLOTS        = 64,
    parameter int MAX_BLOCKS   = 1024,
    parameter int HEADER_BYTES = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmd_valid,
    input  scbsa_pkg::cmd_t                 cmd,
    output logic                            cmd_pop,
    input  logic                            res_full,
    output logic                            res_push,
    output scbsa_pkg::res_t                 res,
    input  logic [15:0]                     block_size,
    input  logic [$clog2(MAX_BLOCKS+1)-1:0] eff_bpp
);
    import scbsa_pkg::*;

    localparam int SW      = $clog2(SLOTS);
    localparam int WORDS   = (MAX_BLOCKS + 31) / 32;
    localparam int WP_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int UNITS_W = $clog2(WORDS + 1);
    localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
    localparam int BMP_AW  = $clog2(SLOTS * WORDS);
    localparam int PG_W    = $clog2(SLOTS + 1);
    localparam int TF_W    = $clog2(SLOTS * MAX_BLOCKS + 1);
    localparam int IDX_W   = WP_W + 5;
    localparam int PROD_W  = IDX_W + 16;
    localparam int CW_W    = CNT_W + WP_W;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_A_CHK = 5'd1;
    localparam logic [4:0] S_W_CHK = 5'd2;
    localparam logic [4:0] S_MUL   = 5'd3;
    localparam logic [4:0] S_ADDR  = 5'd4;
    localparam logic [4:0] S_D_LNK = 5'd5;
    localparam logic [4:0] S_INS   = 5'd6;
    localparam logic [4:0] S_INS_A = 5'd7;
    localparam logic [4:0] S_INS_B = 5'd8;
    localparam logic [4:0] S_D_FIN = 5'd9;
    localparam logic [4:0] S_CLR   = 5'd10;
    localparam logic [4:0] S_F_CHK = 5'd11;
    localparam logic [4:0] S_F_FIN = 5'd12;
    localparam logic [4:0] S_RES   = 5'd13;

    function automatic logic [BMP_AW-1:0] bm_addr(input logic [SW-1:0] s,
                                                  input logic [WP_W-1:0] w);
        bm_addr = BMP_AW'(s) * BMP_AW'(WORDS) + BMP_AW'(w);
    endfunction

    function automatic logic [4:0] lowest_zero(input logic [31:0] w);
        logic [4:0] j;
        j = 5'd0;
        for (int b = 31; b >= 0; b--)
        begin
            if (!w[b])
            begin
                j = 5'(b);
            end
        end
        lowest_zero = j;
    endfunction

    // memories
    logic [SW-1:0]   nx_mem [SLOTS];
    logic [SW-1:0]   pv_mem [SLOTS];
    logic [CW_W-1:0] cw_mem [SLOTS];
    logic [47:0]     pg_mem [SLOTS];
    logic [31:0]     bm_mem [SLOTS*WORDS];

    logic [SLOTS-1:0] nx_vld_reg, pv_vld_reg, cw_vld_reg, in_use_reg;
    logic             clear_all;

    logic [SW-1:0]   nx_ra, pv_ra, cw_ra, pg_ra, nx_wa, pv_wa, cw_wa, pg_wa;
    logic [BMP_AW-1:0] bm_ra, bm_wa;
    logic            nx_we, pv_we, cw_we, pg_we, bm_we, in_use_set, in_use_clr;
    logic [SW-1:0]   nx_wd, pv_wd;
    logic [CW_W-1:0] cw_wd;
    logic [47:0]     pg_wd;
    logic [31:0]     bm_wd;

    logic [SW-1:0]   nx_q, pv_q, nx_ra_q, pv_ra_q;
    logic [CW_W-1:0] cw_q;
    logic            nx_vq, pv_vq, cw_vq;
    logic [47:0]     pg_q;
    logic [31:0]     bm_q;
    logic [SW-1:0]   nx_rd, pv_rd;
    logic [CNT_W-1:0] cw_cnt;
    logic [WP_W-1:0] cw_wp;

    // control state
    logic [4:0]       state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    logic [SW-1:0]    s_reg, s_next, k_reg, k_next, p_reg, p_next;
    logic [SW-1:0]    ins_to_reg, ins_to_next;
    logic             ins_vld_reg, ins_vld_next, ins_add_reg, ins_add_next;
    logic [WP_W-1:0]  wp_reg, wp_next, i_reg, i_next, clr_reg, clr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic             cur_valid_reg, cur_valid_next;
    logic [SW-1:0]    cur_head_reg, cur_head_next, empty_head_reg, empty_head_next;
    logic [PG_W-1:0]  pages_reg, pages_next;
    logic [TF_W-1:0]  tfree_reg, tfree_next;
    res_t             res_reg, res_next;

    logic [UNITS_W-1:0] units;
    logic [4:0]         pad_mod;
    logic [SW-1:0]      s_in;
    logic [WP_W-1:0]    wp_start, wp_inc;
    logic [4:0]         j_bit;
    logic [CNT_W-1:0]   cnt_inc;
    logic [TF_W-1:0]    tf_inc;

    assign units   = UNITS_W'((eff_bpp - CNT_W'(1)) >> 5) + UNITS_W'(1);
    assign pad_mod = eff_bpp[4:0];
    assign s_in    = SW'(cmd.slot);

    // unwritten link entries read as the ring order after reset
    assign nx_rd  = nx_vq ? nx_q : ((nx_ra_q == SW'(SLOTS - 1)) ? '0 : nx_ra_q + SW'(1));
    assign pv_rd  = pv_vq ? pv_q : ((pv_ra_q == '0) ? SW'(SLOTS - 1) : pv_ra_q - SW'(1));
    assign cw_cnt = cw_vq ? cw_q[CW_W-1:WP_W] : '0;
    assign cw_wp  = cw_vq ? cw_q[WP_W-1:0] : '0;

    assign wp_start = (UNITS_W'(cw_wp) >= units) ? '0 : cw_wp;
    assign wp_inc   = ((UNITS_W'(wp_reg) + UNITS_W'(1)) == units) ? '0 : wp_reg + WP_W'(1);
    assign j_bit    = lowest_zero(bm_q);
    assign cnt_inc  = cw_cnt + CNT_W'(1);
    assign tf_inc   = tfree_reg + TF_W'(1);

    assign res = res_reg;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        s_next          = s_reg;
        k_next          = k_reg;
        p_next          = p_reg;
        ins_to_next     = ins_to_reg;
        ins_vld_next    = ins_vld_reg;
        ins_add_next    = ins_add_reg;
        wp_next         = wp_reg;
        i_next          = i_reg;
        clr_next        = clr_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        prod_next       = prod_reg;
        cur_valid_next  = cur_valid_reg;
        cur_head_next   = cur_head_reg;
        empty_head_next = empty_head_reg;
        pages_next      = pages_reg;
        tfree_next      = tfree_reg;
        res_next        = res_reg;

        cmd_pop    = 1'b0;
        res_push   = 1'b0;
        clear_all  = 1'b0;
        nx_ra = s_reg;  pv_ra = s_reg;  cw_ra = s_reg;  pg_ra = s_reg;
        bm_ra = bm_addr(s_reg, wp_reg);
        nx_we = 1'b0;  nx_wa = s_reg;  nx_wd = s_reg;
        pv_we = 1'b0;  pv_wa = s_reg;  pv_wd = s_reg;
        cw_we = 1'b0;  cw_wa = s_reg;  cw_wd = '0;
        pg_we = 1'b0;  pg_wa = s_reg;  pg_wd = cmd_reg.page;
        bm_we = 1'b0;  bm_wa = bm_addr(s_reg, wp_reg);  bm_wd = '0;
        in_use_set = 1'b0;
        in_use_clr = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && !res_full)
                begin
                    cmd_pop  = 1'b1;
                    cmd_next = cmd;
                    res_next = '0;
                    case (cmd.op)
                        MODE_ALLOC:
                        begin
                            if (!cur_valid_reg || tfree_reg == '0)
                            begin
                                res_next.status = ST_NEED_PAGE;
                                state_next      = S_RES;
                            end
                            else
                            begin
                                s_next     = cur_head_reg;
                                k_next     = '0;
                                nx_ra      = cur_head_reg;
                                cw_ra      = cur_head_reg;
                                state_next = S_A_CHK;
                            end
                        end
                        MODE_FREE:
                        begin
                            if (cmd.bad || !in_use_reg[s_in])
                            begin
                                res_next.status = ST_BAD_FREE;
                                state_next      = S_RES;
                            end
                            else
                            begin
                                s_next     = s_in;
                                nx_ra      = s_in;
                                pv_ra      = s_in;
                                cw_ra      = s_in;
                                pg_ra      = s_in;
                                bm_ra      = bm_addr(s_in, WP_W'(cmd.blk >> 5));
                                wp_next    = WP_W'(cmd.blk >> 5);
                                state_next = S_F_CHK;
                            end
                        end
                        MODE_ADD:
                        begin
                            if (pages_reg >= PG_W'(SLOTS))
                            begin
                                res_next.status = ST_NO_EMPTY;
                                state_next      = S_RES;
                            end
                            else
                            begin
                                s_next     = empty_head_reg;
                                nx_ra      = empty_head_reg;
                                pv_ra      = empty_head_reg;
                                state_next = S_D_LNK;
                            end
                        end
                        default:
                        begin
                            state_next = S_RES;
                        end
                    endcase
                end
            end

            // walk the in-use ring for a slot with free blocks
            S_A_CHK:
            begin
                if (cw_cnt != '0)
                begin
                    cnt_next   = cw_cnt;
                    wp_next    = wp_start;
                    i_next     = '0;
                    bm_ra      = bm_addr(s_reg, wp_start);
                    state_next = S_W_CHK;
                end
                else if (nx_rd == cur_head_reg || k_reg == SW'(SLOTS - 1))
                begin
                    res_next.status = ST_NEED_PAGE;
                    state_next      = S_RES;
                end
                else
                begin
                    s_next = nx_rd;
                    k_next = k_reg + SW'(1);
                    nx_ra  = nx_rd;
                    cw_ra  = nx_rd;
                end
            end

            // scan bitmap words from the word pointer
            S_W_CHK:
            begin
                if (bm_q != 32'hFFFF_FFFF)
                begin
                    bm_we      = 1'b1;
                    bm_wd      = bm_q | (32'd1 << j_bit);
                    cw_we      = 1'b1;
                    cw_wd      = {cnt_reg - CNT_W'(1), wp_reg};
                    tfree_next = tfree_reg - TF_W'(1);
                    cur_head_next = s_reg;
                    idx_next   = {wp_reg, j_bit};
                    state_next = S_MUL;
                end
                else if ((UNITS_W'(i_reg) + UNITS_W'(1)) == units)
                begin
                    res_next.status = ST_NEED_PAGE;
                    state_next      = S_RES;
                end
                else
                begin
                    i_next  = i_reg + WP_W'(1);
                    wp_next = wp_inc;
                    bm_ra   = bm_addr(s_reg, wp_inc);
                end
            end

            S_MUL:
            begin
                prod_next  = PROD_W'(idx_reg) * PROD_W'(block_size);
                state_next = S_ADDR;
            end

            S_ADDR:
            begin
                res_next.status = ST_OK;
                res_next.addr   = (64'(pg_q) << PAGE_SHIFT) + 64'(HEADER_BYTES)
                                + 64'(prod_reg);
                res_next.used   = 6'(s_reg);
                state_next      = S_RES;
            end

            // take the empty head off its ring
            S_D_LNK:
            begin
                if (nx_rd != s_reg)
                begin
                    empty_head_next = nx_rd;
                    nx_we = 1'b1;  nx_wa = pv_rd;  nx_wd = nx_rd;
                    pv_we = 1'b1;  pv_wa = nx_rd;  pv_wd = pv_rd;
                end
                ins_to_next  = cur_head_reg;
                ins_vld_next = cur_valid_reg;
                ins_add_next = 1'b1;
                state_next   = S_INS;
            end

            // link slot in front of ins_to, or as a ring of one
            S_INS:
            begin
                if (!ins_vld_reg)
                begin
                    nx_we = 1'b1;
                    pv_we = 1'b1;
                    state_next = ins_add_reg ? S_D_FIN : S_F_FIN;
                end
                else
                begin
                    pv_ra      = ins_to_reg;
                    state_next = S_INS_A;
                end
            end

            S_INS_A:
            begin
                p_next = pv_rd;
                nx_we = 1'b1;  nx_wd = ins_to_reg;
                pv_we = 1'b1;  pv_wd = pv_rd;
                state_next = S_INS_B;
            end

            S_INS_B:
            begin
                nx_we = 1'b1;  nx_wa = p_reg;       nx_wd = s_reg;
                pv_we = 1'b1;  pv_wa = ins_to_reg;  pv_wd = s_reg;
                state_next = ins_add_reg ? S_D_FIN : S_F_FIN;
            end

            S_D_FIN:
            begin
                cur_head_next  = s_reg;
                cur_valid_next = 1'b1;
                pg_we          = 1'b1;
                cw_we          = 1'b1;
                cw_wd          = {eff_bpp, WP_W'(0)};
                in_use_set     = 1'b1;
                pages_next     = pages_reg + PG_W'(1);
                tfree_next     = tfree_reg + TF_W'(eff_bpp);
                clr_next       = '0;
                state_next     = S_CLR;
            end

            // clear the slot's bitmap, padding in the last unit
            S_CLR:
            begin
                bm_we = 1'b1;
                bm_wa = bm_addr(s_reg, clr_reg);
                if ((UNITS_W'(clr_reg) + UNITS_W'(1)) == units && pad_mod != '0)
                begin
                    bm_wd = 32'hFFFF_FFFF << pad_mod;
                end
                if (clr_reg == WP_W'(WORDS - 1))
                begin
                    res_next.status = ST_OK;
                    res_next.used   = 6'(s_reg);
                    state_next      = S_RES;
                end
                else
                begin
                    clr_next = clr_reg + WP_W'(1);
                end
            end

            S_F_CHK:
            begin
                if (!bm_q[cmd_reg.blk[4:0]])
                begin
                    res_next.status = ST_BAD_FREE;
                    state_next      = S_RES;
                end
                else
                begin
                    bm_we = 1'b1;
                    bm_wd = bm_q & ~(32'd1 << cmd_reg.blk[4:0]);
                    if (cnt_inc < eff_bpp)
                    begin
                        cw_we      = 1'b1;
                        cw_wd      = {cnt_inc, cw_wp};
                        tfree_next = tf_inc;
                        state_next = S_RES;
                    end
                    else if (pages_reg <= PG_W'(1))
                    begin
                        // last page: lists and counts back to reset
                        clear_all       = 1'b1;
                        cur_valid_next  = 1'b0;
                        cur_head_next   = '0;
                        empty_head_next = '0;
                        pages_next      = '0;
                        tfree_next      = '0;
                        res_next.status = ST_ALL_REL;
                        res_next.rel    = pg_q;
                        state_next      = S_RES;
                    end
                    else
                    begin
                        tfree_next = (tf_inc >= TF_W'(cnt_inc)) ? tf_inc - TF_W'(cnt_inc) : '0;
                        pages_next = pages_reg - PG_W'(1);
                        cw_we      = 1'b1;
                        in_use_clr = 1'b1;
                        if (cur_head_reg == s_reg)
                        begin
                            cur_head_next = nx_rd;
                        end
                        nx_we = 1'b1;  nx_wa = pv_rd;  nx_wd = nx_rd;
                        pv_we = 1'b1;  pv_wa = nx_rd;  pv_wd = pv_rd;
                        ins_to_next  = empty_head_reg;
                        ins_vld_next = (pages_reg < PG_W'(SLOTS));
                        ins_add_next = 1'b0;
                        state_next   = S_INS;
                    end
                end
            end

            S_F_FIN:
            begin
                empty_head_next = s_reg;
                res_next.status = ST_RELEASED;
                res_next.rel    = pg_q;
                state_next      = S_RES;
            end

            S_RES:
            begin
                res_push   = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // memory arrays
    always_ff @(posedge clk)
    begin
        if (nx_we)
        begin
            nx_mem[nx_wa] <= nx_wd;
        end
        if (pv_we)
        begin
            pv_mem[pv_wa] <= pv_wd;
        end
        if (cw_we)
        begin
            cw_mem[cw_wa] <= cw_wd;
        end
        if (pg_we)
        begin
            pg_mem[pg_wa] <= pg_wd;
        end
        if (bm_we)
        begin
            bm_mem[bm_wa] <= bm_wd;
        end
        nx_q    <= nx_mem[nx_ra];
        pv_q    <= pv_mem[pv_ra];
        cw_q    <= cw_mem[cw_ra];
        pg_q    <= pg_mem[pg_ra];
        bm_q    <= bm_mem[bm_ra];
        nx_ra_q <= nx_ra;
        pv_ra_q <= pv_ra;
    end

    // per-slot valid bits and read-side valid capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nx_vld_reg <= '0;
            pv_vld_reg <= '0;
            cw_vld_reg <= '0;
            in_use_reg <= '0;
            nx_vq      <= 1'b0;
            pv_vq      <= 1'b0;
            cw_vq      <= 1'b0;
        end
        else
        begin
            nx_vq <= nx_vld_reg[nx_ra];
            pv_vq <= pv_vld_reg[pv_ra];
            cw_vq <= cw_vld_reg[cw_ra];
            if (clear_all)
            begin
                nx_vld_reg <= '0;
                pv_vld_reg <= '0;
                cw_vld_reg <= '0;
                in_use_reg <= '0;
            end
            else
            begin
                if (nx_we)
                begin
                    nx_vld_reg[nx_wa] <= 1'b1;
                end
                if (pv_we)
                begin
                    pv_vld_reg[pv_wa] <= 1'b1;
                end
                if (cw_we)
                begin
                    cw_vld_reg[cw_wa] <= 1'b1;
                end
                if (in_use_set)
                begin
                    in_use_reg[s_reg] <= 1'b1;
                end
                if (in_use_clr)
                begin
                    in_use_reg[s_reg] <= 1'b0;
                end
            end
        end
    end

    // datapath holding registers
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        s_reg      <= s_next;
        k_reg      <= k_next;
        p_reg      <= p_next;
        ins_to_reg <= ins_to_next;
        ins_vld_reg <= ins_vld_next;
        ins_add_reg <= ins_add_next;
        wp_reg     <= wp_next;
        i_reg      <= i_next;
        clr_reg    <= clr_next;
        cnt_reg    <= cnt_next;
        idx_reg    <= idx_next;
        prod_reg   <= prod_next;
        res_reg    <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cur_valid_reg  <= 1'b0;
            cur_head_reg   <= '0;
            empty_head_reg <= '0;
            pages_reg      <= '0;
            tfree_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_valid_reg  <= cur_valid_next;
            cur_head_reg   <= cur_head_next;
            empty_head_reg <= empty_head_next;
            pages_reg      <= pages_next;
            tfree_reg      <= tfree_next;
        end
    end
endmodule

@@ tb/sv/tb_size_class_bitmap_slab_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_size_class_bitmap_slab_allocator
// Self-checking bench for the slab allocator: requests are driven through the
// push/full queue, a behavioral allocator model predicts each result, and
// popped results are compared field by field in order.
// ----------------------------------------------------------------------------
import scbsa_pkg::*;

typedef struct {
    logic [2:0]  status;
    logic [63:0] addr;
    logic [47:0] rel;
    logic [5:0]  used;
} alloc_result_t;

class alloc_scoreboard;
    localparam int NSLOT = 64;
    localparam int NBLK  = 1024;
    localparam int NWORD = NBLK / 32;
    localparam int HDR   = 16;

    logic [15:0] blk_bytes;
    logic [10:0] bpp_reg;

    logic [47:0] page_of [NSLOT];
    int          free_cnt [NSLOT];
    int          word_ptr [NSLOT];
    int          nxt [NSLOT];
    int          prv [NSLOT];
    bit          busy [NSLOT];
    logic [31:0] bmap [NSLOT * NWORD];
    bit          head_ok;
    int          head;
    int          empty_ring;
    int          pages;
    int          free_total;

    alloc_result_t pending_q[$];
    int            mismatches;

    function new();
        blk_bytes  = 16'd64;
        bpp_reg    = 11'd1024;
        mismatches = 0;
        foreach (bmap[i]) bmap[i] = '0;
        foreach (page_of[i]) page_of[i] = '0;
        clear_lists();
    endfunction

    function void clear_lists();
        for (int i = 0; i < NSLOT; i++)
        begin
            nxt[i] = (i + 1) % NSLOT;
            prv[i] = (i + NSLOT - 1) % NSLOT;
            free_cnt[i] = 0;
            word_ptr[i] = 0;
            busy[i] = 0;
        end
        head_ok = 0; head = 0; empty_ring = 0; pages = 0; free_total = 0;
    endfunction

    function int blocks();
        int b;
        b = bpp_reg;
        if (b == 0) b = 1;
        if (b > NBLK) b = NBLK;
        return b;
    endfunction

    function int words();
        return ((blocks() - 1) >> 5) + 1;
    endfunction

    function void write_reg(logic idx, logic [15:0] val);
        if (idx == REG_BLOCK_SIZE) blk_bytes = val;
        else bpp_reg = val[10:0];
    endfunction

    function void unlink(int s);
        int p, n;
        p = prv[s]; n = nxt[s];
        nxt[p] = n; prv[n] = p;
    endfunction

    function void link_before(int s, int to, bit to_ok);
        int p;
        if (!to_ok)
        begin
            nxt[s] = s; prv[s] = s;
        end
        else
        begin
            p = prv[to];
            nxt[s] = to; prv[s] = p; nxt[p] = s; prv[to] = s;
        end
    endfunction

    // predicts one request and queues the expected result
    function void note_request(logic [1:0] md, logic [47:0] pg, logic [5:0] sl,
                               logic [9:0] bi);
        alloc_result_t r;
        int s, wp, j, b, u, idx, cnt;
        bit hit, ering_ok;
        logic [31:0] w;
        r.status = ST_OK; r.addr = '0; r.rel = '0; r.used = '0;
        if (md == MODE_ALLOC)
        begin
            r.status = ST_NEED_PAGE;
            if (head_ok && free_total != 0)
            begin
                s = head; hit = 0;
                for (int k = 0; k < NSLOT; k++)
                begin
                    if (free_cnt[s] != 0) begin hit = 1; break; end
                    s = nxt[s];
                    if (s == head) break;
                end
                if (hit)
                begin
                    u = words();
                    wp = word_ptr[s];
                    if (wp >= u) wp = 0;
                    for (int i = 0; i < u; i++)
                    begin
                        w = bmap[s * NWORD + wp];
                        if (w != 32'hFFFF_FFFF)
                        begin
                            for (j = 0; j < 32; j++) if (!w[j]) break;
                            bmap[s * NWORD + wp][j] = 1'b1;
                            word_ptr[s] = wp;
                            free_cnt[s]--; free_total--;
                            head = s;
                            r.status = ST_OK;
                            r.addr = {page_of[s], 16'h0} + 64'(HDR)
                                   + 64'(wp * 32 + j) * 64'(blk_bytes);
                            r.used = s[5:0];
                            break;
                        end
                        wp = (wp + 1 == u) ? 0 : wp + 1;
                    end
                end
            end
        end
        else if (md == MODE_ADD)
        begin
            if (pages >= NSLOT) r.status = ST_NO_EMPTY;
            else
            begin
                s = empty_ring;
                if (nxt[s] != s)
                begin
                    empty_ring = nxt[s];
                    unlink(s);
                end
                link_before(s, head, head_ok);
                head = s; head_ok = 1;
                b = blocks(); u = words();
                for (int i = 0; i < NWORD; i++) bmap[s * NWORD + i] = '0;
                if ((b & 31) != 0)
                    bmap[s * NWORD + u - 1] = ~((32'd1 << (b & 31)) - 32'd1);
                page_of[s] = pg;
                free_cnt[s] = b; word_ptr[s] = 0; busy[s] = 1;
                pages++; free_total += b;
                r.used = s[5:0];
            end
        end
        else if (md == MODE_FREE)
        begin
            s = sl; b = blocks();
            idx = s * NWORD + (bi >> 5);
            if (!busy[s] || bi >= b || !bmap[idx][bi[4:0]]) r.status = ST_BAD_FREE;
            else
            begin
                bmap[idx][bi[4:0]] = 1'b0;
                cnt = free_cnt[s] + 1;
                free_cnt[s] = cnt; free_total++;
                if (cnt >= b)
                begin
                    r.rel = page_of[s];
                    if (pages <= 1)
                    begin
                        clear_lists();
                        r.status = ST_ALL_REL;
                    end
                    else
                    begin
                        ering_ok = pages < NSLOT;
                        free_total = (free_total >= cnt) ? free_total - cnt : 0;
                        pages--;
                        free_cnt[s] = 0; word_ptr[s] = 0; busy[s] = 0;
                        if (head == s) head = nxt[s];
                        unlink(s);
                        link_before(s, empty_ring, ering_ok);
                        empty_ring = s;
                        r.status = ST_RELEASED;
                    end
                end
            end
        end
        pending_q.push_back(r);
    endfunction

    function void check_result(alloc_result_t got);
        alloc_result_t e;
        if (pending_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result status=%0d", got.status);
            return;
        end
        e = pending_q.pop_front();
        if (got.status !== e.status || got.addr !== e.addr || got.rel !== e.rel
            || got.used !== e.used)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch exp st=%0d a=%h r=%h u=%0d got st=%0d a=%h r=%h u=%0d",
                         e.status, e.addr, e.rel, e.used,
                         got.status, got.addr, got.rel, got.used);
        end
    endfunction
endclass

module tb_size_class_bitmap_slab_allocator;
    localparam int LIMIT = 2_000_000;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [1:0]  mode;
    logic [47:0] page_number;
    logic [5:0]  slot_index;
    logic [9:0]  block_index;
    logic        empty;
    logic        pop;
    logic [2:0]  status;
    logic [63:0] block_address;
    logic [47:0] released_page;
    logic [5:0]  used_slot;
    logic        wr_en;
    logic        wr_index;
    logic [15:0] wr_data;

    alloc_scoreboard sb;
    int  cycle;
    bit  steady;        // no idling on either side while set
    // blocks handed out by the allocator, so frees can target live blocks
    logic [15:0] live_q[$];

    size_class_bitmap_slab_allocator u_dut (
        .clk(clk), .rst_n(rst_n),
        .push(push), .full(full), .mode(mode), .page_number(page_number),
        .slot_index(slot_index), .block_index(block_index),
        .empty(empty), .pop(pop), .status(status), .block_address(block_address),
        .released_page(released_page), .used_slot(used_slot),
        .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // cycle limit guard
    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle > LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side: random stalls, compare each popped result
    always @(posedge clk)
    begin
        alloc_result_t got;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                got.status = status; got.addr = block_address;
                got.rel = released_page; got.used = used_slot;
                sb.check_result(got);
            end
            pop <= steady ? 1'b1 : ($urandom_range(0, 99) >= 9);
        end
    end

    // send one request, idling at random before it; push stays high after
    // the accept until the next request or a drain takes it down
    task automatic send(logic [1:0] md, logic [47:0] pg, logic [5:0] sl, logic [9:0] bi);
        while (!steady && $urandom_range(0, 99) < 9)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1; mode <= md; page_number <= pg;
        slot_index <= sl; block_index <= bi;
        @(posedge clk);
        while (full) @(posedge clk);
        sb.note_request(md, pg, sl, bi);
        // remember allocated blocks as slot/block pairs for later frees
        if (md == MODE_ALLOC && sb.pending_q[$].status == ST_OK)
            live_q.push_back({sb.pending_q[$].used,
                              10'((sb.pending_q[$].addr
                                   - {sb.page_of[sb.pending_q[$].used], 16'h0} - 64'd16)
                                  / ((sb.blk_bytes == 0) ? 64'd1 : 64'(sb.blk_bytes)))});
    endtask

    // wait for all results, then let the back end settle before a register write
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        wr_en <= 1'b1; wr_index <= idx; wr_data <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
        wr_en <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [47:0] rand_page();
        return {$urandom(), $urandom()};
    endfunction

    // one random request: mostly allocations and frees of live blocks
    task automatic random_request();
        int pick, k;
        logic [15:0] ent;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            send(MODE_ALLOC, rand_page(), 6'($urandom()), 10'($urandom()));
        else if (pick < 75 && live_q.size() != 0)
        begin
            k = $urandom_range(0, live_q.size() - 1);
            ent = live_q[k];
            live_q.delete(k);
            send(MODE_FREE, rand_page(), ent[15:10], ent[9:0]);
        end
        else if (pick < 87)
            send(MODE_ADD, rand_page(), 6'($urandom()), 10'($urandom()));
        else if (pick < 95)
            send(MODE_FREE, rand_page(), 6'($urandom()), 10'($urandom()));
        else
            send(MODE_NOP, rand_page(), 6'($urandom()), 10'($urandom()));
    endtask

    initial
    begin
        int bpp_set[6] = '{1, 3, 32, 33, 1024, 0};
        sb = new();
        cycle = 0; steady = 1'b0;
        rst_n = 1'b0; push = 1'b0; pop = 1'b0; mode = MODE_ALLOC;
        page_number = '0; slot_index = '0; block_index = '0;
        wr_en = 1'b0; wr_index = REG_BLOCK_SIZE; wr_data = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty allocator, bad frees, no-op, small pages
        write_reg(REG_BLOCK_SIZE, 16'hFFF8);
        write_reg(REG_BPP, 16'd2);
        send(MODE_ALLOC, '0, '0, '0);
        send(MODE_FREE, '0, 6'd63, 10'd1023);
        send(MODE_NOP, 48'hFFFF_FFFF_FFFF, 6'h3F, 10'h3FF);
        send(MODE_ADD, 48'hFFFF_FFFF_FFFF, '0, '0);
        send(MODE_ALLOC, '0, '0, '0);
        send(MODE_ALLOC, '0, '0, '0);
        send(MODE_ALLOC, '0, '0, '0);
        send(MODE_FREE, '0, 6'd0, 10'd5);
        send(MODE_ADD, 48'h0, '0, '0);
        send(MODE_FREE, '0, 6'd0, 10'd0);
        send(MODE_FREE, '0, 6'd0, 10'd0);
        send(MODE_FREE, '0, 6'd0, 10'd1);
        send(MODE_ALLOC, '0, '0, '0);
        send(MODE_FREE, '0, 6'd1, 10'd0);
        // fill every slot, then one more add to hit the no-empty case
        for (int i = 0; i < 65; i++) send(MODE_ADD, rand_page(), '0, '0);
        drain();
        live_q.delete();

        // at bpp=1, 64 allocations, then frees of blocks 0 and 1 in every slot
        write_reg(REG_BPP, 16'd1);
        for (int i = 0; i < 64; i++) send(MODE_ALLOC, '0, '0, '0);
        for (int i = 0; i < 64; i++) send(MODE_FREE, '0, 6'(i), 10'd0);
        for (int i = 0; i < 64; i++) send(MODE_FREE, '0, 6'(i), 10'd1);
        drain();
        live_q.delete();

        // random phases over several register settings
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(REG_BLOCK_SIZE, (ph == 0) ? 16'd8 : 16'($urandom_range(1, 8191) * 8));
            write_reg(REG_BPP, 16'(bpp_set[ph]));
            steady = (ph == 2);
            for (int n = 0; n < 85; n++) random_request();
            drain();
        end
        steady = 1'b0;
        // a pause with everything drained before the last requests
        for (int n = 0; n < 20; n++) random_request();
        drain();

        if (sb.mismatches == 0 && sb.pending_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/core/scbsa_pkg.sv
rtl/core/scbsa_fifo.sv
rtl/core/scbsa_front.sv
rtl/core/scbsa_engine.sv
rtl/core/size_class_bitmap_slab_allocator.sv
tb/sv/tb_size_class_bitmap_slab_allocator.sv
